[sv/bhpq_pkg.sv]
`default_nettype none

package bhpq_pkg;

  localparam int unsigned PRIO_W = 32;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned OCC_W  = 8;
  localparam int unsigned STAT_W = 2;

  // request type codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DQ,
    S_DOWN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[sv/bhpq_req_if.sv]
`default_nettype none

interface bhpq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [bhpq_pkg::PRIO_W-1:0]  priority_req;
  logic        [bhpq_pkg::PAY_W-1:0]   payload;

  modport source (output valid, req_type, priority_req, payload, input ready);
  modport sink   (input valid, req_type, priority_req, payload, output ready);
endinterface

`default_nettype wire

[sv/bhpq_rsp_if.sv]
`default_nettype none

interface bhpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [bhpq_pkg::STAT_W-1:0]  status;
  logic signed [bhpq_pkg::PRIO_W-1:0]  out_priority;
  logic        [bhpq_pkg::PAY_W-1:0]   out_payload;
  logic        [bhpq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

`default_nettype wire

[sv/binary_max_heap_priority_queue_top.sv]
// Enqueue: after the input transfer the new entry rises through S_UP, one level per step.
// Dequeue: S_DQ takes the root and moves the last entry up, which then sinks through S_DOWN;
// S_DQ goes straight to S_DONE when it removes the last entry. Rejected requests (full or empty)
// go straight to S_DONE. Each level is one memory read/compare/write; at most log2(CAPACITY) levels.
// One request in work at a time; the next transfer can be taken while the previous result
// waits in the output register. Reset clears count and valid.
`default_nettype none

module binary_max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY     = 128,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bhpq_req_if.sink   req_i,
  bhpq_rsp_if.source rsp_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned PW = bhpq_pkg::PRIO_W;
  localparam int unsigned OW = bhpq_pkg::PAY_W;

  typedef struct packed {
    logic signed [PW-1:0]           prio;
    logic        [PAYLOAD_BITS-1:0] data;
  } entry_t;

  // heap memory, two read ports, one write port
  entry_t mem [CAPACITY];
  entry_t rd_a_q, rd_b_q;
  logic   mem_we;
  logic   [IW-1:0] waddr, raddr_a, raddr_b;
  entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  bhpq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     pos_q, pos_d;
  entry_t            entry_q, entry_d;
  bhpq_pkg::status_e res_status_q, res_status_d;
  logic signed [PW-1:0]     res_pri_q, res_pri_d;
  logic [PAYLOAD_BITS-1:0]  res_pay_q, res_pay_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic [bhpq_pkg::STAT_W-1:0] rsp_status_q, rsp_status_d;
  logic signed [PW-1:0] rsp_pri_q, rsp_pri_d;
  logic [OW-1:0]        rsp_pay_q, rsp_pay_d;
  logic [bhpq_pkg::OCC_W-1:0] rsp_occ_q, rsp_occ_d;

  logic req_fire, rsp_free, is_full, is_empty;
  logic up_swap, has_left, has_right, pick_right, down_swap;
  logic [IW-1:0] parent_idx, best_idx, child_l, child_r;
  logic [XW-1:0] left_x, right_x, cnt_x;
  entry_t        best;
  logic [CW+7:0]           occ_ext;
  logic [PAYLOAD_BITS+31:0] pay_ext;

  assign req_i.ready = (state_q == bhpq_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign is_full     = (count_q == CW'(CAPACITY));
  assign is_empty    = (count_q == '0);

  // sift-up: hole at pos_q, parent entry arrives on port A
  assign parent_idx = (pos_q - IW'(1)) >> 1;
  assign up_swap    = $signed(entry_q.prio) > $signed(rd_a_q.prio);

  // sift-down: children of pos_q arrive on ports A (left) and B (right)
  assign left_x     = XW'({pos_q, 1'b1});
  assign right_x    = left_x + XW'(1);
  assign cnt_x      = XW'(count_q);
  assign has_left   = left_x < cnt_x;
  assign has_right  = right_x < cnt_x;
  assign pick_right = has_right && ($signed(rd_b_q.prio) > $signed(rd_a_q.prio));
  assign best       = pick_right ? rd_b_q : rd_a_q;
  assign best_idx   = pick_right ? right_x[IW-1:0] : left_x[IW-1:0];
  assign down_swap  = has_left && ($signed(entry_q.prio) < $signed(best.prio));
  assign child_l    = IW'({best_idx, 1'b1});
  assign child_r    = child_l + IW'(1);

  assign occ_ext = {8'd0, count_q};
  assign pay_ext = {32'd0, res_pay_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bhpq_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req_i.req_type == bhpq_pkg::REQ_ENQ) begin
            state_d = is_full ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP;
          end else begin
            state_d = is_empty ? bhpq_pkg::S_DONE : bhpq_pkg::S_DQ;
          end
        end
      end
      bhpq_pkg::S_UP: begin
        if (pos_q == '0 || !up_swap) begin
          state_d = bhpq_pkg::S_DONE;
        end
      end
      bhpq_pkg::S_DQ: begin
        state_d = is_empty ? bhpq_pkg::S_DONE : bhpq_pkg::S_DOWN;
      end
      bhpq_pkg::S_DOWN: begin
        if (!down_swap) begin
          state_d = bhpq_pkg::S_DONE;
        end
      end
      bhpq_pkg::S_DONE: begin
        if (rsp_free) begin
          state_d = bhpq_pkg::S_IDLE;
        end
      end
      default: state_d = bhpq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d      = count_q;
    pos_d        = pos_q;
    entry_d      = entry_q;
    res_status_d = res_status_q;
    res_pri_d    = res_pri_q;
    res_pay_d    = res_pay_q;
    mem_we       = 1'b0;
    waddr        = pos_q;
    wdata        = entry_q;
    raddr_a      = '0;
    raddr_b      = '0;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_pri_d    = rsp_pri_q;
    rsp_pay_d    = rsp_pay_q;
    rsp_occ_d    = rsp_occ_q;
    unique case (state_q)
      bhpq_pkg::S_IDLE: begin
        if (req_fire) begin
          res_status_d = bhpq_pkg::ST_DONE;
          res_pri_d    = '0;
          res_pay_d    = '0;
          if (req_i.req_type == bhpq_pkg::REQ_ENQ) begin
            if (is_full) begin
              res_status_d = bhpq_pkg::ST_FULL;
            end else begin
              entry_d.prio = req_i.priority_req;
              entry_d.data = req_i.payload[PAYLOAD_BITS-1:0];
              pos_d        = count_q[IW-1:0];
              count_d      = count_q + CW'(1);
              raddr_a      = (count_q[IW-1:0] - IW'(1)) >> 1;
            end
          end else begin
            if (is_empty) begin
              res_status_d = bhpq_pkg::ST_EMPTY;
            end else begin
              raddr_a = '0;
              raddr_b = count_q[IW-1:0] - IW'(1);
              count_d = count_q - CW'(1);
            end
          end
        end
      end
      bhpq_pkg::S_UP: begin
        mem_we = 1'b1;
        if (pos_q != '0 && up_swap) begin
          wdata   = rd_a_q;
          pos_d   = parent_idx;
          raddr_a = (parent_idx - IW'(1)) >> 1;
        end
      end
      bhpq_pkg::S_DQ: begin
        res_pri_d = rd_a_q.prio;
        res_pay_d = rd_a_q.data;
        entry_d   = rd_b_q;
        pos_d     = '0;
        raddr_a   = IW'(1);
        raddr_b   = IW'(2);
      end
      bhpq_pkg::S_DOWN: begin
        mem_we = 1'b1;
        if (down_swap) begin
          wdata   = best;
          pos_d   = best_idx;
          raddr_a = child_l;
          raddr_b = child_r;
        end
      end
      bhpq_pkg::S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_pri_d    = res_pri_q;
          rsp_pay_d    = pay_ext[OW-1:0];
          rsp_occ_d    = occ_ext[7:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bhpq_pkg::S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    entry_q      <= entry_d;
    res_status_q <= res_status_d;
    res_pri_q    <= res_pri_d;
    res_pay_q    <= res_pay_d;
    rsp_status_q <= rsp_status_d;
    rsp_pri_q    <= rsp_pri_d;
    rsp_pay_q    <= rsp_pay_d;
    rsp_occ_q    <= rsp_occ_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.out_priority = rsp_pri_q;
  assign rsp_o.out_payload  = rsp_pay_q;
  assign rsp_o.occupancy    = rsp_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_deq_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.req_type == bhpq_pkg::REQ_DEQ && is_empty |=>
      state_q == bhpq_pkg::S_DONE && res_status_q == bhpq_pkg::ST_EMPTY)
    else $error("dequeue on empty heap not rejected");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == bhpq_pkg::S_UP || state_q == bhpq_pkg::S_DOWN))
    else $error("heap write outside sift states");

  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == bhpq_pkg::S_DONE)
    else $error("result raised without completion");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bhpq_pkg::*;

  localparam int unsigned CAPACITY     = 128;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam logic [PAY_W-1:0] PAY_MASK = {PAY_W{1'b1}} >> (PAY_W - PAYLOAD_BITS);
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 24;

  typedef struct packed {
    status_e                  status;
    logic signed [PRIO_W-1:0] prio;
    logic        [PAY_W-1:0]  pay;
    logic        [OCC_W-1:0]  occ;
  } heap_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;
  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_e;

  // Tracks the heap contents for every accepted request and checks the results in order.
  class heap_scoreboard;
    logic signed [PRIO_W-1:0] prio_q [CAPACITY];
    logic        [PAY_W-1:0]  pay_q  [CAPACITY];
    int unsigned count;
    heap_result_t expected_results[$];
    int unsigned errors, checked, enq_done, deq_done, full_rejects, empty_rejects, peak;

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [PRIO_W-1:0] tp;
      logic        [PAY_W-1:0]  td;
      tp = prio_q[a];
      td = pay_q[a];
      prio_q[a] = prio_q[b];
      pay_q[a]  = pay_q[b];
      prio_q[b] = tp;
      pay_q[b]  = td;
    endfunction

    function void note_request(logic rt, logic signed [PRIO_W-1:0] pr, logic [PAY_W-1:0] pl);
      heap_result_t r;
      int unsigned pos, parent, lc, rc, big;
      r.status = ST_DONE;
      r.prio   = '0;
      r.pay    = '0;
      if (rt == REQ_ENQ) begin
        if (count >= CAPACITY) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          pos = count;
          prio_q[pos] = pr;
          pay_q[pos]  = pl & PAY_MASK;
          count++;
          // rise only while strictly greater than the parent
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (prio_q[pos] <= prio_q[parent]) break;
            swap_slots(pos, parent);
            pos = parent;
          end
          enq_done++;
        end
      end else begin
        if (count == 0) begin
          r.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          r.prio = prio_q[0];
          r.pay  = pay_q[0];
          count--;
          prio_q[0] = prio_q[count];
          pay_q[0]  = pay_q[count];
          pos = 0;
          // sink toward the larger child; right only if strictly larger than left
          while (1) begin
            lc = 2 * pos + 1;
            rc = lc + 1;
            if (lc >= count) break;
            big = lc;
            if (rc < count && prio_q[rc] > prio_q[lc]) big = rc;
            if (!(prio_q[pos] < prio_q[big])) break;
            swap_slots(pos, big);
            pos = big;
          end
          deq_done++;
        end
      end
      r.occ = count[OCC_W-1:0];
      if (count > peak) peak = count;
      expected_results.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d prio=%h pay=%h occ=%0d",
                 $time, got.status, got.prio, got.pay, got.occ);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      checked++;
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.prio !== exp_r.prio) begin
        $display("%0t: priority mismatch: expected %h, actual %h", $time, exp_r.prio, got.prio);
        errors++;
      end
      if (got.pay !== exp_r.pay) begin
        $display("%0t: payload mismatch: expected %h, actual %h", $time, exp_r.pay, got.pay);
        errors++;
      end
      if (got.occ !== exp_r.occ) begin
        $display("%0t: occupancy mismatch: expected %0d, actual %0d", $time, exp_r.occ, got.occ);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bhpq_req_if req_bus ();
  bhpq_rsp_if rsp_bus ();

  binary_max_heap_priority_queue_top #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  heap_scoreboard sb = new();
  int unsigned sent;
  int unsigned burst_left;
  int unsigned holds_done;
  bit          hold_request;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: sample at the rising edge
  always @(posedge clk_i) begin
    heap_result_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.status = status_e'(rsp_bus.status);
      got.prio   = rsp_bus.out_priority;
      got.pay    = rsp_bus.out_payload;
      got.occ    = rsp_bus.occupancy;
      sb.check_result(got);
    end
  end

  // receiver backpressure: random segments of different stall patterns, plus long hold-offs
  initial begin : rsp_side
    rx_mode_e mode;
    int unsigned seg, held;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        for (held = 0; held < LONG_HOLD; held++) begin
          @(negedge clk_i);
          rsp_bus.ready <= 1'b0;
        end
        hold_request = 1'b0;
        holds_done++;
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(10, 120);
      for (int k = 0; k < seg && !hold_request; k++) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:     rsp_bus.ready <= 1'b1;
          RX_COIN:     rsp_bus.ready <= $urandom_range(0, 1);
          RX_PERIODIC: rsp_bus.ready <= ((k % 5) < 2);
          default:     rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_request(input logic rt, input logic signed [PRIO_W-1:0] pr,
                              input logic [PAY_W-1:0] pl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= rt;
    req_bus.priority_req <= pr;
    req_bus.payload      <= pl;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(rt, pr, pl);
    sent++;
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $signed($urandom_range(0, 8)) - 4;   // dense: many ties
    if (sel < 7) return $urandom();
    if (sel < 8) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  task automatic issue(input int unsigned enq_pct);
    logic rt;
    rt = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
    if (sent == 250 || sent == 800) hold_request = 1'b1;
    send_request(rt, pick_priority(), $urandom());
  endtask

  initial begin : stimulus
    phase_e ph;
    int unsigned n;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = REQ_ENQ;
    req_bus.priority_req = '0;
    req_bus.payload      = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty reject, extremes, ties at root and among children, then drain
    send_request(REQ_DEQ, '0, '0);
    send_request(REQ_ENQ, '0, '0);
    send_request(REQ_ENQ, 32'sh7fff_ffff, 32'hffff_ffff);
    send_request(REQ_ENQ, 32'sh8000_0000, 32'h1234_5678);
    send_request(REQ_ENQ, '1, 32'ha5a5_a5a5);
    send_request(REQ_ENQ, '0, 32'h1);
    send_request(REQ_ENQ, 32'sh7fff_ffff, 32'h2);
    send_request(REQ_ENQ, 32'sd5, 32'h3);
    send_request(REQ_ENQ, 32'sd5, 32'h4);
    repeat (9) send_request(REQ_DEQ, '1, 32'h5a5a_5a5a);

    // random phases: fill to full, mixed, drain to empty, mixed
    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      case (p % 4)
        0:       ph = PH_FILL;
        2:       ph = PH_DRAIN;
        default: ph = PH_MIXED;
      endcase
      case (ph)
        PH_FILL: begin
          while (sb.count < CAPACITY) issue(90);
          repeat ($urandom_range(1, 4)) issue(100);
        end
        PH_DRAIN: begin
          while (sb.count > 0) issue(10);
          repeat ($urandom_range(1, 3)) issue(0);
        end
        default: begin
          n = $urandom_range(40, 150);
          repeat (n) issue($urandom_range(35, 65));
        end
      endcase
    end
    @(negedge clk_i);
    req_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d enqueues, %0d dequeues, %0d full and %0d empty rejects",
             sb.enq_done, sb.deq_done, sb.full_rejects, sb.empty_rejects);
    $display("peak occupancy %0d, %0d results checked, %0d long receiver hold-offs",
             sb.peak, sb.checked, holds_done);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
sv/bhpq_pkg.sv
sv/bhpq_req_if.sv
sv/bhpq_rsp_if.sv
sv/binary_max_heap_priority_queue_top.sv
tb/testbench.sv
